FILE: rtl/assert_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checks that the property holds at every clock edge outside reset.
`define ASSERT_CLK(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Checks that the condition never holds outside reset.
`define ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CLK(name, clk, rst_n, prop)
`define ASSERT_NEVER(name, clk, rst_n, cond)

`endif

`endif

FILE: rtl/gfla_pkg.sv
package gfla_pkg;

  localparam int ADDR_W    = 32;
  localparam int ESIZE_W   = 17;
  localparam int CNT_W     = 11;
  localparam int CFG_IDX_W = 2;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd1;

  localparam logic [ESIZE_W-1:0] ENTRY_SIZE_RST   = 17'd4;
  localparam logic [ADDR_W-1:0]  BASE_ADDRESS_RST = 32'd0;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_PUT_FULL  = 2'd2,
    ST_CORRUPT   = 2'd3
  } gfla_status_e;

  typedef struct packed {
    logic              cmd;
    logic [ADDR_W-1:0] put_address;
  } gfla_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] got_address;
    gfla_status_e      status;
    logic [CNT_W-1:0]  free_count;
    logic [CNT_W-1:0]  capacity;
  } gfla_rsp_t;

endpackage

FILE: rtl/growing_free_list_allocator_top.sv
// Free-list allocator: each get or put is registered first, and a new item is accepted
// in the cycle after its result is registered, never before.
// A get on an empty stack under MAX_ENTRIES grows the pool via S_MUL_NEXT, S_CHECK, S_BASE,
// S_FILL, writing new slots one at a time through the single write port of the slot memory.
// rst_ni clears control state and the configuration registers asynchronously; the slot
// memory is not cleared, since only slots below the stack count are ever used.
`include "assert_macros.svh"

module growing_free_list_allocator_top #(
  parameter int MAX_ENTRIES     = 1024,
  parameter int INITIAL_ENTRIES = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  gfla_pkg::gfla_req_t                   in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output gfla_pkg::gfla_rsp_t                   out_data_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [gfla_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [gfla_pkg::ADDR_W-1:0]           cfg_data_i
);

  import gfla_pkg::*;

  localparam int AW     = $clog2(MAX_ENTRIES);
  localparam int CW     = $clog2(MAX_ENTRIES + 1);
  localparam int PW     = CW + ESIZE_W;
  localparam int SLOT_W = ADDR_W + 1;
  localparam logic [CW-1:0] MAX_CAP  = CW'(MAX_ENTRIES);
  localparam logic [CW-1:0] INIT_CAP = CW'(INITIAL_ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MUL_NEXT,
    S_CHECK,
    S_BASE,
    S_FILL
  } state_e;

  state_e              state_q;
  logic [ESIZE_W-1:0]  es_q;
  logic [ADDR_W-1:0]   base_q;
  logic [CW-1:0]       count_q;
  logic [CW-1:0]       cap_q;
  logic [CW-1:0]       next_q;
  gfla_req_t           req_q;
  logic [PW-1:0]       prod_q;
  logic [ADDR_W-1:0]   gen_q;
  logic [AW-1:0]       idx_q;
  logic                out_valid_q;
  gfla_rsp_t           out_q;

  logic                in_fire;
  logic                out_free;
  logic                out_load;
  logic [CW-1:0]       top_w;
  logic                put_ok;
  logic [CW-1:0]       fresh;
  logic [CW-1:0]       fresh_m1;
  logic [CW:0]         dbl;
  logic [CW-1:0]       next_calc;
  logic [CW-1:0]       mul_a;
  logic [PW-1:0]       product;
  logic [63:0]         prod_ext;
  logic                overflow;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [SLOT_W-1:0]   ram_wdata;
  logic                ram_re;
  logic [SLOT_W-1:0]   ram_rdata;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign top_w    = count_q - CW'(1);
  assign put_ok   = (count_q < cap_q);
  assign fresh    = next_q - cap_q;
  assign fresh_m1 = fresh - CW'(1);
  assign dbl      = {cap_q, 1'b0};

  always_comb begin
    if (cap_q == '0) begin
      next_calc = INIT_CAP;
    end else if (dbl > {1'b0, MAX_CAP}) begin
      next_calc = MAX_CAP;
    end else begin
      next_calc = dbl[CW-1:0];
    end
  end

  // The multiplier is shared: first the grown capacity, then the old one.
  assign mul_a    = (state_q == S_MUL_NEXT) ? next_q : cap_q;
  assign product  = PW'(mul_a) * PW'(es_q);
  assign prod_ext = 64'(prod_q);
  assign overflow = |prod_ext[63:ADDR_W];

  // A result is registered in every state that finishes an item.
  assign out_load = out_free &&
                    ((state_q == S_EXEC &&
                      (req_q.cmd == CMD_PUT || count_q != '0 || cap_q == MAX_CAP)) ||
                     (state_q == S_CHECK && overflow) ||
                     (state_q == S_FILL && idx_q == fresh_m1[AW-1:0]));

  // Each slot stores its address with a valid bit on top.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count_q[AW-1:0];
    ram_wdata = {(req_q.put_address != '0), req_q.put_address};
    if (state_q == S_FILL) begin
      ram_we    = 1'b1;
      ram_waddr = idx_q;
      ram_wdata = {1'b1, gen_q};
    end else if (state_q == S_EXEC && req_q.cmd == CMD_PUT && put_ok && out_free) begin
      ram_we = 1'b1;
    end
  end

  assign ram_re = in_fire && (in_data_i.cmd == CMD_GET);

  gfla_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (MAX_ENTRIES)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (top_w[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      es_q        <= ENTRY_SIZE_RST;
      base_q      <= BASE_ADDRESS_RST;
      count_q     <= '0;
      cap_q       <= '0;
      next_q      <= '0;
      req_q       <= '0;
      prod_q      <= '0;
      gen_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_ENTRY_SIZE:   es_q   <= cfg_data_i[ESIZE_W-1:0];
          CFG_BASE_ADDRESS: base_q <= cfg_data_i;
          default: ;
        endcase
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            req_q   <= in_data_i;
            state_q <= S_EXEC;
          end
        end

        S_EXEC: begin
          if (req_q.cmd == CMD_PUT) begin
            if (out_free) begin
              out_q.got_address <= '0;
              out_q.capacity    <= CNT_W'(cap_q);
              if (put_ok) begin
                count_q          <= count_q + CW'(1);
                out_q.status     <= ST_OK;
                out_q.free_count <= CNT_W'(count_q + CW'(1));
              end else begin
                out_q.status     <= ST_PUT_FULL;
                out_q.free_count <= CNT_W'(count_q);
              end
              state_q <= S_IDLE;
            end
          end else if (count_q != '0) begin
            if (out_free) begin
              count_q          <= top_w;
              out_q.free_count <= CNT_W'(top_w);
              out_q.capacity   <= CNT_W'(cap_q);
              if (ram_rdata[ADDR_W]) begin
                out_q.got_address <= ram_rdata[ADDR_W-1:0];
                out_q.status      <= ST_OK;
              end else begin
                out_q.got_address <= '0;
                out_q.status      <= ST_CORRUPT;
              end
              state_q <= S_IDLE;
            end
          end else if (cap_q == MAX_CAP) begin
            if (out_free) begin
              out_q.got_address <= '0;
              out_q.status      <= ST_EXHAUSTED;
              out_q.free_count  <= CNT_W'(count_q);
              out_q.capacity    <= CNT_W'(cap_q);
              state_q           <= S_IDLE;
            end
          end else begin
            next_q  <= next_calc;
            state_q <= S_MUL_NEXT;
          end
        end

        S_MUL_NEXT: begin
          prod_q  <= product;
          state_q <= S_CHECK;
        end

        S_CHECK: begin
          // The grown pool must stay addressable in 32 bits.
          if (overflow) begin
            if (out_free) begin
              out_q.got_address <= '0;
              out_q.status      <= ST_EXHAUSTED;
              out_q.free_count  <= CNT_W'(count_q);
              out_q.capacity    <= CNT_W'(cap_q);
              state_q           <= S_IDLE;
            end
          end else begin
            prod_q  <= product;
            state_q <= S_BASE;
          end
        end

        S_BASE: begin
          gen_q   <= base_q + prod_ext[ADDR_W-1:0];
          idx_q   <= '0;
          state_q <= S_FILL;
        end

        S_FILL: begin
          // The last new slot is popped at once by the waiting get.
          if (idx_q == fresh_m1[AW-1:0]) begin
            if (out_free) begin
              out_q.got_address <= gen_q;
              out_q.status      <= ST_OK;
              out_q.free_count  <= CNT_W'(fresh_m1);
              out_q.capacity    <= CNT_W'(next_q);
              count_q           <= fresh_m1;
              cap_q             <= next_q;
              state_q           <= S_IDLE;
            end
          end else begin
            idx_q <= idx_q + AW'(1);
            gen_q <= gen_q + ADDR_W'(es_q);
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_count_within_cap, clk_i, rst_ni, count_q <= cap_q)
  `ASSERT_NEVER(a_cap_above_max, clk_i, rst_ni, cap_q > MAX_CAP)
  `ASSERT_CLK(a_cap_never_shrinks, clk_i, rst_ni, 1'b1 |=> cap_q >= $past(cap_q))
  `ASSERT_CLK(a_fill_in_range, clk_i, rst_ni, state_q == S_FILL |-> CW'(idx_q) < fresh)

endmodule

FILE: rtl/gfla_ram.sv
module gfla_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
